[rtl/color_blend_hsv_or_rgb_defines.svh]
// Assertion macros for the color blender RTL.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef COLOR_BLEND_HSV_OR_RGB_DEFINES_SVH
`define COLOR_BLEND_HSV_OR_RGB_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on clk_i, with reset masking the check
`define CBHR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cbhr: assertion failed");
// Check a property on clk_i, also while reset is low
`define CBHR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cbhr: assertion failed");
`else
`define CBHR_ASSERT(lbl, prop)
`define CBHR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/cbhr_pkg.sv]
// Shared constants, types and the blend function of the color blender.
// No dependencies; used by color_blend_hsv_or_rgb and the testbench checker.
package cbhr_pkg;

  localparam int CW       = 8;             // channel width
  localparam int STEPS    = 256;           // hue steps per sector
  localparam int STEP_W   = $clog2(STEPS);
  localparam int HUE_FULL = 6 * STEPS;
  localparam int HUE_W    = STEP_W + 3;
  localparam int SEC_W    = HUE_W - STEP_W;
  localparam int SAT_SH   = 16;
  localparam int SAT_ONE  = 1 << SAT_SH;
  localparam int SAT_W    = SAT_SH + 1;
  localparam int W_W      = 9;
  localparam int W_SH     = 8;
  localparam int W_MAX    = 1 << W_SH;
  localparam int BL_W     = SAT_W + W_W + 1;
  localparam int NUM_W    = CW + SAT_SH;   // divider numerator and quotient
  localparam int DEN_SH   = SAT_SH + STEP_W;
  localparam int DEN      = 1 << DEN_SH;
  localparam int DEN_W    = DEN_SH + 1;
  localparam int PROD_W   = CW + DEN_W;

  localparam logic KIND_RGB = 1'b1;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_UP   = 3'd0,
    SEC_GRN_DOWN = 3'd1,
    SEC_GRN_UP   = 3'd2,
    SEC_BLU_DOWN = 3'd3,
    SEC_BLU_UP   = 3'd4,
    SEC_RED_DOWN = 3'd5
  } sector_e;

  // Weighted mean with rounding: (a*(256-w) + b*w + 128) >> 8
  function automatic logic [SAT_W-1:0] blend(logic [SAT_W-1:0] a, logic [SAT_W-1:0] b,
                                             logic [W_W-1:0] w);
    logic [BL_W-1:0] acc;
    acc = BL_W'(a) * BL_W'(W_W'(W_MAX) - w) + BL_W'(b) * BL_W'(w)
        + BL_W'(W_MAX / 2);
    return acc[SAT_W+W_SH-1:W_SH];
  endfunction

endpackage

[rtl/color_blend_hsv_or_rgb.sv]
// Color blender top level: HSV or RGB blend of two colors, fully pipelined.
// Depends on cbhr_pkg, cbhr_div and color_blend_hsv_or_rgb_defines.svh.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-----------------------------------------
//  in      | in_valid_i | in_stall_o  | kind_i, first_*_i, second_*_i, weight_i
//  out     | out_valid_o| out_stall_i | out_red_o, out_green_o, out_blue_o
//
// One transaction per clock unless the output stalls; the path runs through
// the four 24-stage dividers (saturation and hue fraction of both colors) plus
// input, prepare, hue, blend, two back-conversion stages and the output register.
// Reset clears only the valid bits of the pipeline.
// A stalled output with a result waiting freezes the whole pipeline.
`include "color_blend_hsv_or_rgb_defines.svh"

module color_blend_hsv_or_rgb (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [cbhr_pkg::CW-1:0] first_red_i,
  input  logic [cbhr_pkg::CW-1:0] first_green_i,
  input  logic [cbhr_pkg::CW-1:0] first_blue_i,
  input  logic [cbhr_pkg::CW-1:0] second_red_i,
  input  logic [cbhr_pkg::CW-1:0] second_green_i,
  input  logic [cbhr_pkg::CW-1:0] second_blue_i,
  input  logic [cbhr_pkg::W_W-1:0] weight_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [cbhr_pkg::CW-1:0] out_red_o,
  output logic [cbhr_pkg::CW-1:0] out_green_o,
  output logic [cbhr_pkg::CW-1:0] out_blue_o
);
  import cbhr_pkg::*;

  typedef struct packed {
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [CW-1:0]    v;
    logic [CW-1:0]    dl;
    logic             hv;
    logic             mz;
    logic             neg;
    logic [HUE_W-1:0] base;
    logic [NUM_W-1:0] nsat;
    logic [NUM_W-1:0] nhue;
  } prep_t;

  typedef struct packed {
    logic [CW-1:0]    v;
    logic             hv;
    logic             mz;
    logic             neg;
    logic [HUE_W-1:0] base;
  } color_t;

  typedef struct packed {
    logic          kind;
    rgb_t          rgb;
    logic [W_W-1:0] w;
    color_t        x;
    color_t        y;
  } side_t;

  typedef struct packed {
    logic [HUE_W-1:0] h;
    logic [SAT_W-1:0] s;
    logic [CW-1:0]    v;
    logic             hv;
  } hsv_t;

  // Max, min, sector base and rounded numerators for one color
  function automatic prep_t hsv_prep(rgb_t c);
    logic [CW-1:0] mx, mn, pos, ng, diff;
    prep_t o;
    mx = (c.r > c.g) ? c.r : c.g;
    mn = (c.r < c.g) ? c.r : c.g;
    if (c.b > mx) mx = c.b;
    if (c.b < mn) mn = c.b;
    o.v  = mx;
    o.dl = mx - mn;
    if (c.r == mx) begin
      o.base = '0;
      pos = c.g;
      ng  = c.b;
    end else if (c.g == mx) begin
      o.base = HUE_W'(2 * STEPS);
      pos = c.b;
      ng  = c.r;
    end else begin
      o.base = HUE_W'(4 * STEPS);
      pos = c.r;
      ng  = c.g;
    end
    o.neg  = ng > pos;
    diff   = o.neg ? ng - pos : pos - ng;
    o.hv   = o.dl != '0;
    o.mz   = mx == '0;
    o.nsat = {o.dl, SAT_SH'(0)} + NUM_W'(mx >> 1);
    o.nhue = NUM_W'({diff, STEP_W'(0)}) + NUM_W'(o.dl >> 1);
    return o;
  endfunction

  // Assemble hue and saturation from the quotients
  function automatic hsv_t hue_fix(color_t c, logic [NUM_W-1:0] qh, logic [NUM_W-1:0] qs);
    logic [HUE_W:0] hsum;
    hsv_t o;
    if (c.neg) begin
      hsum = {1'b0, c.base} + (HUE_W+1)'(HUE_FULL) - (HUE_W+1)'(qh[STEP_W:0]);
      if (hsum >= (HUE_W+1)'(HUE_FULL)) hsum = hsum - (HUE_W+1)'(HUE_FULL);
    end else begin
      hsum = {1'b0, c.base} + (HUE_W+1)'(qh[STEP_W:0]);
    end
    o.h  = c.hv ? hsum[HUE_W-1:0] : '0;
    o.s  = c.mz ? '0 : qs[SAT_W-1:0];
    o.v  = c.v;
    o.hv = c.hv;
    return o;
  endfunction

  logic en;

  // Stage 0: input register
  logic           s0_valid_q;
  logic           s0_kind_q;
  rgb_t           s0_a_q, s0_b_q;
  logic [W_W-1:0] s0_w_q;
  logic [W_W-1:0] w_cl;

  // Stage 1: prepared division operands
  logic           s1_valid_q;
  logic           s1_kind_q;
  rgb_t           s1_rgb_q;
  logic [W_W-1:0] s1_w_q;
  prep_t          s1_x_q, s1_y_q;
  prep_t          x_prep, y_prep;
  rgb_t           rgb_bl;

  // Divider side line
  logic [NUM_W-1:0] vl_q;
  side_t            sd_q [NUM_W];
  logic [NUM_W-1:0] qxs, qxh, qys, qyh;

  // Stage 2: HSV of both colors
  logic           s2_valid_q;
  logic           s2_kind_q;
  rgb_t           s2_rgb_q;
  logic [W_W-1:0] s2_w_q;
  hsv_t           s2_x_q, s2_y_q;

  // Stage 3: blended HSV
  logic s3_valid_q;
  logic s3_kind_q;
  rgb_t s3_rgb_q;
  hsv_t s3_m_q;

  // Stage 4: first products of the back conversion
  logic                s4_valid_q;
  logic                s4_kind_q;
  rgb_t                s4_rgb_q;
  logic [CW-1:0]       s4_v_q;
  logic                s4_hv_q;
  logic                s4_zero_q;
  logic [SEC_W-1:0]    s4_sec_q;
  logic [DEN_W-1:0]    s4_sf_q, s4_sg_q;
  logic [CW+SAT_W-1:0] s4_pp_q;
  logic [HUE_W-1:0]    h4;
  logic [STEP_W-1:0]   f4;

  // Stage 5: p, q, t
  logic             s5_valid_q;
  logic             s5_kind_q;
  rgb_t             s5_rgb_q;
  logic [CW-1:0]    s5_v_q, s5_p_q, s5_q_q, s5_t_q;
  logic             s5_hv_q;
  logic             s5_zero_q;
  logic [SEC_W-1:0] s5_sec_q;
  logic [CW+SAT_W-1:0] p_sum;
  logic [PROD_W-1:0]   q_prod, t_prod;

  // Output register
  logic out_valid_q;
  rgb_t out_q, out_d;

  // Advance the whole pipeline unless a waiting result is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Clamp the weight at 256
  assign w_cl = (weight_i > W_W'(W_MAX)) ? W_W'(W_MAX) : weight_i;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      vl_q        <= '0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q;
      vl_q        <= {vl_q[NUM_W-2:0], s1_valid_q};
      s2_valid_q  <= vl_q[NUM_W-1];
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  // Stage 0 and 1 payload
  assign x_prep = hsv_prep(s0_a_q);
  assign y_prep = hsv_prep(s0_b_q);
  assign rgb_bl.r = CW'(blend(SAT_W'(s0_a_q.r), SAT_W'(s0_b_q.r), s0_w_q));
  assign rgb_bl.g = CW'(blend(SAT_W'(s0_a_q.g), SAT_W'(s0_b_q.g), s0_w_q));
  assign rgb_bl.b = CW'(blend(SAT_W'(s0_a_q.b), SAT_W'(s0_b_q.b), s0_w_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_kind_q <= kind_i;
      s0_a_q    <= '{r: first_red_i, g: first_green_i, b: first_blue_i};
      s0_b_q    <= '{r: second_red_i, g: second_green_i, b: second_blue_i};
      s0_w_q    <= w_cl;
      s1_kind_q <= s0_kind_q;
      s1_rgb_q  <= rgb_bl;
      s1_w_q    <= s0_w_q;
      s1_x_q    <= x_prep;
      s1_y_q    <= y_prep;
    end
  end

  // Saturation and hue fraction dividers for both colors
  cbhr_div #(.NW(NUM_W), .DW(CW)) u_div_xs (
    .clk_i, .en_i(en), .num_i(s1_x_q.nsat), .den_i(s1_x_q.v),  .quo_o(qxs));
  cbhr_div #(.NW(NUM_W), .DW(CW)) u_div_xh (
    .clk_i, .en_i(en), .num_i(s1_x_q.nhue), .den_i(s1_x_q.dl), .quo_o(qxh));
  cbhr_div #(.NW(NUM_W), .DW(CW)) u_div_ys (
    .clk_i, .en_i(en), .num_i(s1_y_q.nsat), .den_i(s1_y_q.v),  .quo_o(qys));
  cbhr_div #(.NW(NUM_W), .DW(CW)) u_div_yh (
    .clk_i, .en_i(en), .num_i(s1_y_q.nhue), .den_i(s1_y_q.dl), .quo_o(qyh));

  // Carry the rest of the transaction alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= '{kind: s1_kind_q, rgb: s1_rgb_q, w: s1_w_q,
                   x: '{v: s1_x_q.v, hv: s1_x_q.hv, mz: s1_x_q.mz,
                        neg: s1_x_q.neg, base: s1_x_q.base},
                   y: '{v: s1_y_q.v, hv: s1_y_q.hv, mz: s1_y_q.mz,
                        neg: s1_y_q.neg, base: s1_y_q.base}};
      for (int k = 1; k < NUM_W; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Stage 2 and 3: finish HSV, then blend each component
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_kind_q <= sd_q[NUM_W-1].kind;
      s2_rgb_q  <= sd_q[NUM_W-1].rgb;
      s2_w_q    <= sd_q[NUM_W-1].w;
      s2_x_q    <= hue_fix(sd_q[NUM_W-1].x, qxh, qxs);
      s2_y_q    <= hue_fix(sd_q[NUM_W-1].y, qyh, qys);
      s3_kind_q <= s2_kind_q;
      s3_rgb_q  <= s2_rgb_q;
      s3_m_q.hv <= s2_x_q.hv && s2_y_q.hv;
      s3_m_q.h  <= (s2_x_q.hv && s2_y_q.hv)
                   ? HUE_W'(blend(SAT_W'(s2_x_q.h), SAT_W'(s2_y_q.h), s2_w_q)) : '0;
      s3_m_q.s  <= blend(s2_x_q.s, s2_y_q.s, s2_w_q);
      s3_m_q.v  <= CW'(blend(SAT_W'(s2_x_q.v), SAT_W'(s2_y_q.v), s2_w_q));
    end
  end

  // Stage 4: sector, fraction and the saturation products
  assign h4 = (s3_m_q.h >= HUE_W'(HUE_FULL)) ? '0 : s3_m_q.h;
  assign f4 = h4[STEP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_kind_q <= s3_kind_q;
      s4_rgb_q  <= s3_rgb_q;
      s4_v_q    <= s3_m_q.v;
      s4_hv_q   <= s3_m_q.hv;
      s4_zero_q <= s3_m_q.s == '0;
      s4_sec_q  <= h4[HUE_W-1:STEP_W];
      s4_sf_q   <= DEN_W'(s3_m_q.s) * DEN_W'(f4);
      s4_sg_q   <= DEN_W'(s3_m_q.s) * DEN_W'((STEP_W+1)'(STEPS) - (STEP_W+1)'(f4));
      s4_pp_q   <= (CW+SAT_W)'(s3_m_q.v) * (CW+SAT_W)'(SAT_W'(SAT_ONE) - s3_m_q.s);
    end
  end

  // Stage 5: round p, q and t
  assign p_sum  = s4_pp_q + (CW+SAT_W)'(SAT_ONE / 2);
  assign q_prod = PROD_W'(s4_v_q) * PROD_W'(DEN_W'(DEN) - s4_sf_q) + PROD_W'(DEN / 2);
  assign t_prod = PROD_W'(s4_v_q) * PROD_W'(DEN_W'(DEN) - s4_sg_q) + PROD_W'(DEN / 2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_kind_q <= s4_kind_q;
      s5_rgb_q  <= s4_rgb_q;
      s5_v_q    <= s4_v_q;
      s5_hv_q   <= s4_hv_q;
      s5_zero_q <= s4_zero_q;
      s5_sec_q  <= s4_sec_q;
      s5_p_q    <= p_sum[CW+SAT_SH-1:SAT_SH];
      s5_q_q    <= q_prod[CW+DEN_SH-1:DEN_SH];
      s5_t_q    <= t_prod[CW+DEN_SH-1:DEN_SH];
    end
  end

  // Pick the output color
  always_comb begin
    out_d = '{r: s5_v_q, g: s5_p_q, b: s5_q_q};
    if (s5_kind_q == KIND_RGB) begin
      out_d = s5_rgb_q;
    end else if (s5_zero_q) begin
      out_d = s5_hv_q ? '0 : '{r: s5_v_q, g: s5_v_q, b: s5_v_q};
    end else begin
      case (sector_e'(s5_sec_q))
        SEC_RED_UP:   out_d = '{r: s5_v_q, g: s5_t_q, b: s5_p_q};
        SEC_GRN_DOWN: out_d = '{r: s5_q_q, g: s5_v_q, b: s5_p_q};
        SEC_GRN_UP:   out_d = '{r: s5_p_q, g: s5_v_q, b: s5_t_q};
        SEC_BLU_DOWN: out_d = '{r: s5_p_q, g: s5_q_q, b: s5_v_q};
        SEC_BLU_UP:   out_d = '{r: s5_t_q, g: s5_p_q, b: s5_v_q};
        default:      out_d = '{r: s5_v_q, g: s5_p_q, b: s5_q_q};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q.r;
  assign out_green_o = out_q.g;
  assign out_blue_o  = out_q.b;

  // Assertions
  `CBHR_ASSERT(a_stall_freezes_line, in_stall_o |=> $stable(vl_q))
  `CBHR_ASSERT(a_accept_enters, in_valid_i && !in_stall_o |=> s0_valid_q)
  `CBHR_ASSERT(a_out_from_last, $rose(out_valid_o) |-> $past(s5_valid_q))
  `CBHR_ASSERT_ALWAYS(a_reset_clears, !rst_ni |-> !out_valid_o && !s0_valid_q)

endmodule

[rtl/cbhr_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Used by color_blend_hsv_or_rgb; no package dependency.
module cbhr_div #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

[dv/cbhr_checker.sv]
// Checker for the color blender: watches both channels, predicts each blended
// color and compares it with the block's output. Depends on cbhr_pkg.
module cbhr_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     kind_i,
  input  logic [cbhr_pkg::CW-1:0]  first_red_i,
  input  logic [cbhr_pkg::CW-1:0]  first_green_i,
  input  logic [cbhr_pkg::CW-1:0]  first_blue_i,
  input  logic [cbhr_pkg::CW-1:0]  second_red_i,
  input  logic [cbhr_pkg::CW-1:0]  second_green_i,
  input  logic [cbhr_pkg::CW-1:0]  second_blue_i,
  input  logic [cbhr_pkg::W_W-1:0] weight_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [cbhr_pkg::CW-1:0]  out_red_i,
  input  logic [cbhr_pkg::CW-1:0]  out_green_i,
  input  logic [cbhr_pkg::CW-1:0]  out_blue_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbhr_pkg::*;

  typedef struct {
    longint h;
    longint s;
    longint v;
    bit     hv;
  } hsv_t;

  typedef struct {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } color_t;

  color_t expected_colors[$];

  function automatic longint round_div(longint n, longint d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return (a * (256 - w) + b * w + 128) >>> 8;
  endfunction

  function automatic hsv_t rgb_to_hsv(longint r, longint g, longint b);
    hsv_t o;
    longint mx, mn, delta, base, pos, neg, mag;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    o.v = mx; o.h = 0; o.s = 0; o.hv = 0;
    if (mx == 0) return o;
    delta = mx - mn;
    o.s = round_div(delta * SAT_ONE, mx);
    if (delta == 0) return o;
    if (r == mx) begin
      base = 0; pos = g; neg = b;
    end else if (g == mx) begin
      base = 2 * STEPS; pos = b; neg = r;
    end else begin
      base = 4 * STEPS; pos = r; neg = g;
    end
    if (pos >= neg) begin
      o.h = base + round_div((pos - neg) * STEPS, delta);
    end else begin
      mag = round_div((neg - pos) * STEPS, delta);
      o.h = (base + HUE_FULL - mag) % HUE_FULL;
    end
    o.hv = 1;
    return o;
  endfunction

  function automatic color_t hsv_to_rgb(hsv_t c);
    color_t o;
    longint h, f, p, q, t, den, v;
    sector_e sec;
    v = c.v;
    if (c.s == 0) begin
      o.red = c.hv ? '0 : CW'(v);
      o.green = o.red;
      o.blue = o.red;
      return o;
    end
    h = c.hv ? c.h : 0;
    if (h >= HUE_FULL) h = 0;
    sec = sector_e'(h / STEPS);
    f = h % STEPS;
    den = longint'(SAT_ONE) * STEPS;
    p = round_div(v * (SAT_ONE - c.s), SAT_ONE);
    q = round_div(v * (den - c.s * f), den);
    t = round_div(v * (den - c.s * (STEPS - f)), den);
    case (sec)
      SEC_RED_UP:   begin o.red = CW'(v); o.green = CW'(t); o.blue = CW'(p); end
      SEC_GRN_DOWN: begin o.red = CW'(q); o.green = CW'(v); o.blue = CW'(p); end
      SEC_GRN_UP:   begin o.red = CW'(p); o.green = CW'(v); o.blue = CW'(t); end
      SEC_BLU_DOWN: begin o.red = CW'(p); o.green = CW'(q); o.blue = CW'(v); end
      SEC_BLU_UP:   begin o.red = CW'(t); o.green = CW'(p); o.blue = CW'(v); end
      default:      begin o.red = CW'(v); o.green = CW'(p); o.blue = CW'(q); end
    endcase
    return o;
  endfunction

  function automatic color_t predict_blend(logic kind, logic [CW-1:0] ar, ag, ab,
                                           logic [CW-1:0] br, bg, bb,
                                           logic [W_W-1:0] weight);
    color_t o;
    hsv_t x, y, m;
    longint w;
    w = (weight > W_MAX) ? W_MAX : weight;
    if (kind == KIND_RGB) begin
      o.red = CW'(mix(ar, br, w));
      o.green = CW'(mix(ag, bg, w));
      o.blue = CW'(mix(ab, bb, w));
    end else begin
      x = rgb_to_hsv(ar, ag, ab);
      y = rgb_to_hsv(br, bg, bb);
      m.hv = x.hv && y.hv;
      m.h = m.hv ? mix(x.h, y.h, w) : 0;
      m.s = mix(x.s, y.s, w);
      m.v = mix(x.v, y.v, w);
      o = hsv_to_rgb(m);
    end
    return o;
  endfunction

  assign pending_o = expected_colors.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin
    color_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_colors.push_back(predict_blend(kind_i, first_red_i, first_green_i,
          first_blue_i, second_red_i, second_green_i, second_blue_i, weight_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result rgb %h %h %h", $time, out_red_i,
                   out_green_i, out_blue_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_colors.pop_front();
          if (want.red !== out_red_i || want.green !== out_green_i ||
              want.blue !== out_blue_i) begin
            $display("%0t: mismatch expected rgb %h %h %h actual %h %h %h", $time,
                     want.red, want.green, want.blue, out_red_i, out_green_i,
                     out_blue_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb_color_blend_hsv_or_rgb.sv]
// Testbench top for the color blender: clock, reset, stimulus and verdict.
// Depends on cbhr_pkg, color_blend_hsv_or_rgb and cbhr_checker.
module tb_color_blend_hsv_or_rgb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbhr_pkg::*;

  localparam int LATENCY = 31;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 0, rst_ni = 1;
  logic in_valid_i = 0, in_stall_o, kind_i = 0;
  logic [CW-1:0] first_red_i = 0, first_green_i = 0, first_blue_i = 0;
  logic [CW-1:0] second_red_i = 0, second_green_i = 0, second_blue_i = 0;
  logic [W_W-1:0] weight_i = 0;
  logic out_valid_o, out_stall_i = 0;
  logic [CW-1:0] out_red_o, out_green_o, out_blue_o;
  int fail_count, pending, cycle_count = 0;
  bit calm = 0;

  color_blend_hsv_or_rgb dut (.*);

  cbhr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i,
    .first_red_i, .first_green_i, .first_blue_i, .second_red_i,
    .second_green_i, .second_blue_i, .weight_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_red_i(out_red_o), .out_green_i(out_green_o),
    .out_blue_i(out_blue_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Abort on a runaway run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall, one long hold-off, calm stretch
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && hold == 0 && cycle_count > 300 && cycle_count < 310) hold = 200;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 33);
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_colors(logic kind, logic [CW-1:0] ar, ag, ab, br, bg, bb,
                             logic [W_W-1:0] w);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    first_red_i <= ar; first_green_i <= ag; first_blue_i <= ab;
    second_red_i <= br; second_green_i <= bg; second_blue_i <= bb;
    weight_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_channel();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  initial begin
    logic [CW-1:0] g;
    logic [W_W-1:0] w;
    #1 rst_ni = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // Directed: extremes, gray and black inputs, weight clamp, both modes
    for (int k = 0; k < 2; k++) begin
      send_colors(1'(k), 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 9'd0);
      send_colors(1'(k), 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 9'd256);
      send_colors(1'(k), 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 9'd511);
      send_colors(1'(k), 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 9'd128);
      send_colors(1'(k), 8'h80, 8'h80, 8'h80, 8'h10, 8'h20, 8'hf0, 9'd100);
      send_colors(1'(k), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 9'd300);
      send_colors(1'(k), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
      send_colors(1'(k), 8'h55, 8'haa, 8'h33, 8'hff, 8'h00, 8'h80, 9'd257);
      send_colors(1'(k), 8'h10, 8'hff, 8'hff, 8'hff, 8'h10, 8'hff, 9'd64);
      send_colors(1'(k), 8'hff, 8'h00, 8'h01, 8'hff, 8'hff, 8'h00, 9'd192);
    end
    // Random: wide mix with frequent extremes and gray colors
    for (int n = 0; n < 800; n++) begin
      calm = (n >= 400 && n < 500);
      w = ($urandom_range(9) == 0) ? W_W'($urandom) : W_W'($urandom_range(256));
      if ($urandom_range(7) == 0) begin
        g = CW'($urandom);
        send_colors(1'($urandom), g, g, g, pick_channel(), pick_channel(),
                    pick_channel(), w);
      end else begin
        send_colors(1'($urandom), pick_channel(), pick_channel(), pick_channel(),
                    pick_channel(), pick_channel(), pick_channel(), w);
      end
    end
    calm = 0;
    in_valid_i <= 0;
    while (pending > 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
